// ===== sv/sv39ptw_pkg.sv =====
`default_nettype none

package sv39ptw_pkg;

    // Fixed Sv39 geometry.
    localparam int INDEX_BITS       = 9;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int PPN_W            = 44;
    localparam int PA_W             = 56;
    localparam int VA_W             = 64;
    localparam int VA_KEEP_W        = 39;
    localparam int LEVEL_W          = 2;
    localparam int STATUS_W         = 3;

    // Defaults for the top-level parameters.
    localparam int LEVELS_DEF        = 3;
    localparam int VA_LIMIT_BITS_DEF = 38;

    // Page table entry bit positions.
    localparam int PTE_V_BIT   = 0;
    localparam int PTE_U_BIT   = 4;
    localparam int PTE_PPN_LSB = 10;

    // Input transaction kinds.
    typedef enum logic {
        CMD_TRANSLATE = 1'b0,
        CMD_MEM_RESP  = 1'b1
    } cmd_t;

    // Output transaction kinds.
    typedef enum logic {
        KIND_READ_REQ = 1'b0,
        KIND_RESULT   = 1'b1
    } kind_t;

    // Translation status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 3'd0,
        STATUS_RANGE      = 3'd1,
        STATUS_NOT_MAPPED = 3'd2,
        STATUS_NOT_USER   = 3'd3,
        STATUS_UNEXPECTED = 3'd4
    } status_t;

    // Walk state carried from one transaction to the next.
    typedef struct packed {
        logic                 busy;
        logic [LEVEL_W-1:0]   level;
        logic [VA_KEEP_W-1:0] vaddr;
    } walk_state_t;

    // One result transaction.
    typedef struct packed {
        kind_t           kind;
        logic [PA_W-1:0] read_addr;
        logic [PA_W-1:0] phys_addr;
        status_t         status;
    } walk_result_t;

    // Table index of a virtual address at a given level; levels beyond the
    // kept address bits index entry zero.
    function automatic logic [INDEX_BITS-1:0] table_index(
        input logic [VA_KEEP_W-1:0] va,
        input logic [LEVEL_W-1:0]   lvl
    );
        logic [INDEX_BITS-1:0] idx;
        case (lvl)
            2'd0:    idx = va[20:12];
            2'd1:    idx = va[29:21];
            2'd2:    idx = va[38:30];
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sv39ptw_step.sv =====
`default_nettype none

// Decodes one transaction against the current walk state and produces the
// next walk state and the result transaction.
module sv39ptw_step
    import sv39ptw_pkg::*;
#(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int VA_LIMIT_BITS = VA_LIMIT_BITS_DEF
) (
    input  walk_state_t        cur,
    input  logic [PPN_W-1:0]   root_ppn,
    input  logic               cmd,
    input  logic [VA_W-1:0]    virt_addr,
    input  logic [VA_W-1:0]    mem_word,
    output walk_state_t        nxt,
    output walk_result_t       res
);

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);

    logic                   va_over;
    logic [PPN_W-1:0]       pte_ppn;
    logic [LEVEL_W-1:0]     lower_level;

    assign va_over     = |virt_addr[VA_W-1:VA_LIMIT_BITS];
    assign pte_ppn     = mem_word[PTE_PPN_LSB +: PPN_W];
    assign lower_level = cur.level - LEVEL_W'(1);

    always_comb begin
        nxt           = cur;
        res.kind      = KIND_RESULT;
        res.read_addr = '0;
        res.phys_addr = '0;
        res.status    = STATUS_OK;

        if (cmd == CMD_TRANSLATE) begin
            // New request: busy and range checks, then read the top-level entry.
            if (cur.busy) begin
                res.status = STATUS_UNEXPECTED;
            end else if (va_over) begin
                res.status = STATUS_RANGE;
            end else begin
                nxt.busy      = 1'b1;
                nxt.level     = TOP_LEVEL;
                nxt.vaddr     = virt_addr[VA_KEEP_W-1:0];
                res.kind      = KIND_READ_REQ;
                res.read_addr = {root_ppn,
                                 table_index(virt_addr[VA_KEEP_W-1:0], TOP_LEVEL),
                                 3'b000};
            end
        end else begin
            // Memory response: follow a valid entry, stop at an invalid one or finish at the leaf.
            if (!cur.busy) begin
                res.status = STATUS_UNEXPECTED;
            end else if (!mem_word[PTE_V_BIT]) begin
                nxt.busy   = 1'b0;
                nxt.level  = '0;
                res.status = STATUS_NOT_MAPPED;
            end else if (cur.level != '0) begin
                nxt.level     = lower_level;
                res.kind      = KIND_READ_REQ;
                res.read_addr = {pte_ppn, table_index(cur.vaddr, lower_level), 3'b000};
            end else begin
                nxt.busy = 1'b0;
                if (!mem_word[PTE_U_BIT]) begin
                    res.status = STATUS_NOT_USER;
                end else begin
                    res.phys_addr = {pte_ppn, {PAGE_OFFSET_BITS{1'b0}}};
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sv39_page_table_walker.sv =====
`default_nettype none

// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tuser: cmd; tdata: virt_addr, mem_word
// m_axis    out  m_axis_tvalid/tready     tuser: kind; tdata: read_addr, phys_addr, status
// cfg       in   cfg_we                   cfg_wdata: root_table_page
//
// Every input transaction yields exactly one output transaction, valid in the cycle after
// the input is taken. One input transaction is taken per cycle while s_axis_tready is
// high; the walk state and the output register update in the same cycle, so the rate is
// set by the single result register. s_axis_tready drops only while the result register
// is full and not being taken. aresetn is synchronous and active low; it clears the walk
// state, the root register and the output valid.
module sv39_page_table_walker
    import sv39ptw_pkg::*;
#(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int VA_LIMIT_BITS = VA_LIMIT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_we,
    input  logic [43:0]      cfg_wdata,      // root_table_page

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [127:0]     s_axis_tdata,   // [63:0] virt_addr, [127:64] mem_word
    input  logic             s_axis_tuser,   // cmd

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [119:0]     m_axis_tdata,   // [55:0] read_addr, [111:56] phys_addr,
                                             // [114:112] status, [119:115] zero
    output logic             m_axis_tuser    // kind
);

    walk_state_t      state_reg;
    walk_state_t      state_next;
    walk_result_t     res_next;
    walk_result_t     out_reg;
    logic             out_valid_reg;
    logic [PPN_W-1:0] root_reg;
    logic             in_fire;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Per-transaction decode.
    sv39ptw_step #(
        .LEVELS        (LEVELS),
        .VA_LIMIT_BITS (VA_LIMIT_BITS)
    ) u_step (
        .cur       (state_reg),
        .root_ppn  (root_reg),
        .cmd       (s_axis_tuser),
        .virt_addr (s_axis_tdata[63:0]),
        .mem_word  (s_axis_tdata[127:64]),
        .nxt       (state_next),
        .res       (res_next)
    );

    // Root table register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_we) begin
            root_reg <= cfg_wdata;
        end
    end

    // Walk state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                state_reg <= state_next;
            end
            if (in_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {5'b0, out_reg.status, out_reg.phys_addr, out_reg.read_addr};

endmodule

`default_nettype wire

// ===== verif/sv39ptw_walk_check_pkg.sv =====
`timescale 1ns / 1ps

package sv39ptw_walk_check_pkg;

    import sv39ptw_pkg::*;

    // Tracks the walker state, predicts one result per accepted transaction and
    // compares the results that come back in order.
    class walk_scoreboard;
        logic [PPN_W-1:0]     root_page;
        bit                   walking;
        int unsigned          level;
        logic [VA_KEEP_W-1:0] walk_vaddr;
        walk_result_t         expected_q[$];
        int unsigned          failures;

        function new();
            root_page  = '0;
            walking    = 1'b0;
            level      = 0;
            walk_vaddr = '0;
            failures   = 0;
        endfunction

        function void set_root(input logic [PPN_W-1:0] value);
            root_page = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Byte address of the page that a physical page number names.
        function logic [PA_W-1:0] page_base(input logic [PPN_W-1:0] ppn);
            return {ppn, {PAGE_OFFSET_BITS{1'b0}}};
        endfunction

        // Read of the entry for the current level inside the table at base.
        function walk_result_t read_request(input logic [PA_W-1:0] base);
            walk_result_t          r;
            logic [INDEX_BITS-1:0] idx;
            r           = '0;
            idx         = INDEX_BITS'(walk_vaddr >> (PAGE_OFFSET_BITS + INDEX_BITS * level));
            r.kind      = KIND_READ_REQ;
            r.read_addr = base + {idx, 3'b000};
            return r;
        endfunction

        // Works out the result of one accepted input transaction.
        function void note_input(input logic cmd, input logic [VA_W-1:0] va,
                                 input logic [63:0] entry);
            walk_result_t r;
            r      = '0;
            r.kind = KIND_RESULT;
            if (cmd == CMD_TRANSLATE) begin
                if (walking) begin
                    r.status = STATUS_UNEXPECTED;
                end else if (va >= (64'd1 << VA_LIMIT_BITS_DEF)) begin
                    r.status = STATUS_RANGE;
                end else begin
                    walking    = 1'b1;
                    level      = LEVELS_DEF - 1;
                    walk_vaddr = va[VA_KEEP_W-1:0];
                    r          = read_request(page_base(root_page));
                end
            end else if (!walking) begin
                r.status = STATUS_UNEXPECTED;
            end else if (!entry[PTE_V_BIT]) begin
                walking  = 1'b0;
                level    = 0;
                r.status = STATUS_NOT_MAPPED;
            end else if (level != 0) begin
                // Valid pointer entries are followed without looking at R/W/X.
                level = level - 1;
                r     = read_request(page_base(entry[PTE_PPN_LSB +: PPN_W]));
            end else begin
                walking = 1'b0;
                if (!entry[PTE_U_BIT])
                    r.status = STATUS_NOT_USER;
                else
                    r.phys_addr = page_base(entry[PTE_PPN_LSB +: PPN_W]);
            end
            expected_q.push_back(r);
        endfunction

        function void report(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
            failures++;
            if (failures <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want_v,
                         got_v);
        endfunction

        // Compares one accepted result transaction with the oldest prediction.
        function void check_result(input logic got_kind, input logic [PA_W-1:0] got_read,
                                   input logic [PA_W-1:0] got_phys,
                                   input logic [STATUS_W-1:0] got_status);
            walk_result_t want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result transaction with no prediction pending", $realtime);
                return;
            end
            want = expected_q.pop_front();
            if (got_kind !== want.kind)
                report("kind", 64'(want.kind), 64'(got_kind));
            if (got_read !== want.read_addr)
                report("read_addr", 64'(want.read_addr), 64'(got_read));
            if (got_phys !== want.phys_addr)
                report("phys_addr", 64'(want.phys_addr), 64'(got_phys));
            if (got_status !== want.status)
                report("status", 64'(want.status), 64'(got_status));
        endfunction

        function void check_drained();
            if (expected_q.size() != 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0d predicted results never arrived", expected_q.size());
            end
        endfunction
    endclass

endpackage

// ===== verif/sv39_page_table_walker_test.sv =====
`timescale 1ns / 1ps

module sv39_page_table_walker_test;

    import sv39ptw_pkg::*;
    import sv39ptw_walk_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASE_ITEMS  = 475;
    localparam logic [63:0] VA_LIMIT     = 64'd1 << VA_LIMIT_BITS_DEF;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_we        = 1'b0;
    logic [43:0]  cfg_wdata     = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tuser;

    walk_scoreboard sb;
    int unsigned    src_idle_pct  = 9;
    int unsigned    sink_idle_pct = 66;
    int unsigned    items_sent    = 0;
    int unsigned    cycles        = 0;

    sv39_page_table_walker #(
        .LEVELS        (LEVELS_DEF),
        .VA_LIMIT_BITS (VA_LIMIT_BITS_DEF)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The result side stalls at random according to the current setting.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every accepted transaction on either side goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64]);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[55:0], m_axis_tdata[111:56],
                            m_axis_tdata[114:112]);
    end

    // Hard limit on the run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Presents one transaction after a random gap and waits until it is taken.
    task automatic send_item(input cmd_t cmd, input logic [63:0] va,
                             input logic [63:0] entry);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {entry, va};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Root register writes happen only with the walker drained.
    task automatic write_root(input logic [43:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_root(value);
    endtask

    task automatic directed_items();
        // Response with no walk in progress, then the address limit and the all-ones address, both out of range.
        send_item(CMD_MEM_RESP, '0, '1);
        send_item(CMD_TRANSLATE, VA_LIMIT, '0);
        send_item(CMD_TRANSLATE, '1, '1);
        // Highest legal address walked through all-ones entries, with a request
        // arriving in the middle of the walk.
        send_item(CMD_TRANSLATE, VA_LIMIT - 1, '0);
        send_item(CMD_MEM_RESP, '0, '1);
        send_item(CMD_TRANSLATE, '0, '0);
        send_item(CMD_MEM_RESP, '0, '1);
        send_item(CMD_MEM_RESP, '0, '1);
        // Leaf that is valid but not user-accessible.
        send_item(CMD_TRANSLATE, '0, '1);
        send_item(CMD_MEM_RESP, '1, 64'h1);
        send_item(CMD_MEM_RESP, '1, 64'h1);
        send_item(CMD_MEM_RESP, '1, 64'h1);
        // Invalid entries at the top, middle and leaf levels.
        send_item(CMD_TRANSLATE, 64'h0000_0015_5555_5000, '0);
        send_item(CMD_MEM_RESP, '0, 64'h0);
        send_item(CMD_TRANSLATE, 64'h0000_002A_AAAA_A000, '0);
        send_item(CMD_MEM_RESP, '0, 64'h1);
        send_item(CMD_MEM_RESP, '0, 64'h2);
        send_item(CMD_TRANSLATE, 64'h0000_0000_0000_0FFF, '0);
        send_item(CMD_MEM_RESP, '0, 64'h1);
        send_item(CMD_MEM_RESP, '0, 64'h1);
        send_item(CMD_MEM_RESP, '0, 64'h10);
        // Reserved bits set and a zero page number all the way down.
        send_item(CMD_TRANSLATE, 64'h0000_0020_1020_3123, '0);
        send_item(CMD_MEM_RESP, '0, 64'hFFC0_0000_0000_0011);
        send_item(CMD_MEM_RESP, '0, 64'hFFC0_0000_0000_0011);
        send_item(CMD_MEM_RESP, '0, 64'hFFC0_0000_0000_0011);
    endtask

    // One well-formed walk with random content, sometimes cut short by an
    // invalid entry or disturbed by a request while busy.
    task automatic random_walk();
        logic [63:0] va;
        logic [63:0] entry;
        int          fail_level;
        int          lvl;
        va = rand64() & (VA_LIMIT - 1);
        case ($urandom_range(15))
            0:       va = VA_LIMIT - 1;
            1:       va = '0;
            default: ;
        endcase
        send_item(CMD_TRANSLATE, va, rand64());
        fail_level = ($urandom_range(9) == 0) ? int'($urandom_range(LEVELS_DEF - 1)) : -1;
        for (lvl = LEVELS_DEF - 1; lvl >= 0; lvl--) begin
            if ($urandom_range(19) == 0)
                send_item(CMD_TRANSLATE, rand64(), rand64());
            entry            = rand64();
            entry[PTE_V_BIT] = (lvl != fail_level);
            if (lvl == 0 && $urandom_range(7) != 0)
                entry[PTE_U_BIT] = 1'b1;
            send_item(CMD_MEM_RESP, rand64(), entry);
            if (lvl == fail_level)
                break;
        end
    endtask

    // Mostly walks, the rest stray responses and requests with random addresses.
    task automatic random_items(input int unsigned count);
        int unsigned start;
        logic [63:0] va;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(99) < 85) begin
                random_walk();
            end else begin
                va = ($urandom_range(3) == 0) ? VA_LIMIT : rand64();
                send_item(cmd_t'($urandom_range(1)), va, rand64());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Highest root page, sender rarely idle, receiver mostly stalled.
        write_root('1);
        directed_items();
        random_items(PHASE_ITEMS);

        // Root page zero, sender mostly idle, receiver rarely stalled.
        write_root('0);
        src_idle_pct  = 66;
        sink_idle_pct = 9;
        random_items(PHASE_ITEMS);

        // Random root page at full rate on both sides.
        write_root(44'(rand64()));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_items(PHASE_ITEMS);

        drain();
        sb.check_drained();
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
